// ===== sv/vhat_pkg.sv =====
// Shared types, constants and helpers for the vector heading core.
// Depends on nothing; every other file imports it.
package vhat_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 16;
  localparam int GUARD_BITS    = 24;
  localparam int TABLE_LEN     = 24;
  localparam int NSTAGE        = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // Field widths of the ports
  localparam int FIELD_W   = 16;
  localparam int HEAD_W    = 16;
  localparam int ANGLE_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Coordinate datapath: input, guard bits, CORDIC gain and sign headroom
  localparam int DATA_W = COORD_WIDTH + GUARD_BITS + 3;

  localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ROUND_HALF   = 32'h0000_8000;
  localparam logic [HEAD_W-1:0]  QUARTER_HEAD = 16'd16384;
  localparam logic [HEAD_W-1:0]  CCW_RESET    = 16'h0000;
  localparam logic [HEAD_W-1:0]  CW_RESET     = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARC_CCW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ARC_CW  = 1'b1;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [ANGLE_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // One vector in flight through the rotation stages
  typedef struct packed {
    logic [DATA_W-1:0]  u;
    logic [DATA_W-1:0]  v;
    logic [ANGLE_W-1:0] acc;
    logic               zero;
  } vhat_work_t;

  // Arc limits handed to the output stage
  typedef struct packed {
    logic [HEAD_W-1:0] ccw;
    logic [HEAD_W-1:0] cw;
  } vhat_arc_t;

  // Sign-extend a coordinate from its low COORD_WIDTH bits
  function automatic logic signed [COORD_WIDTH-1:0] ext_coord(input logic [FIELD_W-1:0] raw);
    logic [COORD_WIDTH+FIELD_W-1:0] wide;
    wide = {{COORD_WIDTH{1'b0}}, raw};
    return $signed(wide[COORD_WIDTH-1:0]);
  endfunction

endpackage

// ===== sv/vector_heading_with_arc_test_core.sv =====
// Top level of the vector heading core: arc registers and the pipeline.
// Depends on vhat_pkg, vhat_pre, vhat_cordic and vhat_post.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | in_vec_x, in_vec_y
//   out     | output    | out_valid / out_ready  | out_heading, out_in_arc
//   cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request enters per cycle unless a stalled output has backed the pipeline up. It has
// one input stage, one stage per micro-rotation and one output stage.
// Synchronous active-low reset empties the pipeline and restores the arc limits.
// A stalled output holds its stage; earlier stages keep filling until all are full.
// Configuration writes are taken every cycle.
module vector_heading_with_arc_test_core import vhat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIELD_W-1:0]   in_vec_x,
  input  logic [FIELD_W-1:0]   in_vec_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [HEAD_W-1:0]    out_heading,
  output logic                 out_in_arc,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HEAD_W-1:0]    cfg_data
);

  vhat_arc_t  arc_r;
  logic       pre_valid, pre_ready;
  vhat_work_t pre_data;
  logic       rot_valid, rot_ready;
  vhat_work_t rot_data;

  assign cfg_ready = 1'b1;

  // Write the arc limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arc_r.ccw <= CCW_RESET;
      arc_r.cw  <= CW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ARC_CCW: arc_r.ccw <= cfg_data;
        REG_ARC_CW:  arc_r.cw  <= cfg_data;
        default: ;
      endcase
    end
  end

  vhat_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_vec_x  (in_vec_x),
    .in_vec_y  (in_vec_y),
    .out_valid (pre_valid),
    .out_ready (pre_ready),
    .out_data  (pre_data)
  );

  vhat_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pre_valid),
    .in_ready  (pre_ready),
    .in_data   (pre_data),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_data  (rot_data)
  );

  vhat_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (rot_valid),
    .in_ready    (rot_ready),
    .in_data     (rot_data),
    .arc         (arc_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_heading (out_heading),
    .out_in_arc  (out_in_arc)
  );

  // Equal limits accept every heading
  a_full_arc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (arc_r.ccw == arc_r.cw) |-> out_in_arc)
    else $error("equal arc limits rejected a heading");

  // An ordinary arc only accepts headings between its limits
  a_plain_arc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (arc_r.ccw < arc_r.cw) && out_in_arc
      |-> (out_heading >= arc_r.ccw) && (out_heading <= arc_r.cw))
    else $error("heading outside ordinary arc flagged inside");

  // Input backpressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

endmodule

// ===== sv/vhat_pre.sv =====
// Input stage: coordinate extension, zero test and half-turn pre-rotation.
// Depends on vhat_pkg.
module vhat_pre import vhat_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] in_vec_x,
  input  logic [FIELD_W-1:0] in_vec_y,
  output logic               out_valid,
  input  logic               out_ready,
  output vhat_work_t         out_data
);

  logic       vld_r;
  vhat_work_t dat_r;
  vhat_work_t dat_nxt;

  logic signed [COORD_WIDTH-1:0] x_c, y_c;
  logic signed [DATA_W-1:0]      x_s, y_s;

  // Scale both components and fold the left half plane over
  always_comb begin
    x_c = ext_coord(in_vec_x);
    y_c = ext_coord(in_vec_y);
    x_s = DATA_W'(x_c) <<< GUARD_BITS;
    y_s = DATA_W'(y_c) <<< GUARD_BITS;
    dat_nxt.zero = (x_c == '0) && (y_c == '0);
    if (y_s < 0) begin
      dat_nxt.u   = -y_s;
      dat_nxt.v   = -x_s;
      dat_nxt.acc = HALF_TURN;
    end else begin
      dat_nxt.u   = y_s;
      dat_nxt.v   = x_s;
      dat_nxt.acc = '0;
    end
  end

  assign in_ready = !vld_r || out_ready;

  // Advance when the next stage takes the request or this one is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = dat_r;

endmodule

// ===== sv/vhat_cordic.sv =====
// Vectoring CORDIC, one registered micro-rotation per stage.
// Depends on vhat_pkg.
module vhat_cordic import vhat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  vhat_work_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output vhat_work_t out_data
);

  logic       vld_r   [NSTAGE];
  vhat_work_t dat_r   [NSTAGE];
  logic       src_vld [NSTAGE];
  vhat_work_t src_dat [NSTAGE];
  logic       rdy     [NSTAGE+1];

  assign rdy[NSTAGE] = out_ready;

  for (genvar k = 0; k < NSTAGE; k++) begin : g_stg
    logic signed [DATA_W-1:0] u_s, v_s, du, dv;
    vhat_work_t               dat_nxt;

    // Pick the stage source: the input port or the previous stage
    if (k == 0) begin : g_first
      assign src_vld[k] = in_valid;
      assign src_dat[k] = in_data;
    end else begin : g_next
      assign src_vld[k] = vld_r[k-1];
      assign src_dat[k] = dat_r[k-1];
    end

    assign rdy[k] = !vld_r[k] || rdy[k+1];

    // Rotate toward the u axis by atan(2^-k)
    always_comb begin
      u_s          = $signed(src_dat[k].u);
      v_s          = $signed(src_dat[k].v);
      du           = v_s >>> k;
      dv           = u_s >>> k;
      dat_nxt.zero = src_dat[k].zero;
      if (!v_s[DATA_W-1]) begin
        dat_nxt.u   = u_s + du;
        dat_nxt.v   = v_s - dv;
        dat_nxt.acc = src_dat[k].acc + ATAN_TABLE[k];
      end else begin
        dat_nxt.u   = u_s - du;
        dat_nxt.v   = v_s + dv;
        dat_nxt.acc = src_dat[k].acc - ATAN_TABLE[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld[k]) begin
        dat_r[k] <= dat_nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTAGE-1];
  assign out_data  = dat_r[NSTAGE-1];

endmodule

// ===== sv/vhat_post.sv =====
// Output stage: heading rounding, zero-vector override and arc test.
// Depends on vhat_pkg.
module vhat_post import vhat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vhat_work_t        in_data,
  input  vhat_arc_t         arc,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HEAD_W-1:0] out_heading,
  output logic              out_in_arc
);

  logic              vld_r;
  logic [HEAD_W-1:0] heading_r, heading_nxt;
  logic              in_arc_r, in_arc_nxt;
  logic [ANGLE_W-1:0] acc_rnd;

  // Round to the nearest heading step; full turn wraps on its own
  always_comb begin
    acc_rnd     = in_data.acc + ROUND_HALF;
    heading_nxt = in_data.zero ? QUARTER_HEAD : acc_rnd[ANGLE_W-1 -: HEAD_W];
    if (arc.ccw < arc.cw) begin
      in_arc_nxt = (heading_nxt >= arc.ccw) && (heading_nxt <= arc.cw);
    end else begin
      in_arc_nxt = (heading_nxt <= arc.cw) || (heading_nxt >= arc.ccw);
    end
  end

  assign in_ready = !vld_r || out_ready;

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      heading_r <= heading_nxt;
      in_arc_r  <= in_arc_nxt;
    end
  end

  assign out_valid   = vld_r;
  assign out_heading = heading_r;
  assign out_in_arc  = in_arc_r;

endmodule

// ===== verif/vector_heading_with_arc_test_core_tb.sv =====
// Testbench for vector_heading_with_arc_test_core: heading and arc-test checks.
// Depends on vhat_pkg for port widths and register indexes; drives all three channels
// and scores every result against an in-bench CORDIC heading predictor.
module vector_heading_with_arc_test_core_tb;
  import vhat_pkg::*;

  localparam int ROT_STAGES  = 16;
  localparam int GUARD_SHIFT = 24;
  localparam int PIPE_DEPTH  = 18;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 500;
  localparam int RUN_LIMIT   = 4000000;

  localparam logic [HEAD_W-1:0] HEAD_QUARTER = 16'd16384;
  localparam logic [31:0]       TURN_HALF    = 32'h8000_0000;
  localparam logic [31:0]       STEP_ROUND   = 32'h0000_8000;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ARCTAN_STEP [ROT_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct {
    logic [HEAD_W-1:0] heading;
    logic              in_arc;
  } heading_result_t;

  // Predict headings and arc flags, hold them in order and score the results
  class heading_checker;
    logic [HEAD_W-1:0] ccw_limit;
    logic [HEAD_W-1:0] cw_limit;
    heading_result_t   pending_headings [$];
    int                errors;

    function new();
      ccw_limit = 16'h0000;
      cw_limit  = 16'hFFFF;
      errors    = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [HEAD_W-1:0] data);
      if (idx == REG_ARC_CCW) begin
        ccw_limit = data;
      end else if (idx == REG_ARC_CW) begin
        cw_limit = data;
      end
    endfunction

    function logic [HEAD_W-1:0] calc_heading(logic signed [FIELD_W-1:0] x,
                                             logic signed [FIELD_W-1:0] y);
      longint      u;
      longint      v;
      longint      du;
      longint      dv;
      logic [31:0] acc;
      logic [31:0] rounded;
      if (x == 0 && y == 0) begin
        return HEAD_QUARTER;
      end
      u   = longint'(y) <<< GUARD_SHIFT;
      v   = longint'(x) <<< GUARD_SHIFT;
      acc = '0;
      // Fold the left half plane onto the right one
      if (u < 0) begin
        u   = -u;
        v   = -v;
        acc = TURN_HALF;
      end
      for (int i = 0; i < ROT_STAGES; i++) begin
        du = v >>> i;
        dv = u >>> i;
        if (v >= 0) begin
          u   = u + du;
          v   = v - dv;
          acc = acc + ARCTAN_STEP[i];
        end else begin
          u   = u - du;
          v   = v + dv;
          acc = acc - ARCTAN_STEP[i];
        end
      end
      rounded = acc + STEP_ROUND;
      return rounded[31:16];
    endfunction

    function logic arc_hit(logic [HEAD_W-1:0] h);
      if (ccw_limit < cw_limit) begin
        return (h >= ccw_limit) && (h <= cw_limit);
      end
      return (h <= cw_limit) || (h >= ccw_limit);
    endfunction

    function void note_request(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y);
      heading_result_t r;
      r.heading = calc_heading(x, y);
      r.in_arc  = arc_hit(r.heading);
      pending_headings.push_back(r);
    endfunction

    task check_result(logic [HEAD_W-1:0] heading, logic in_arc);
      heading_result_t r;
      if (pending_headings.size() == 0) begin
        report($sformatf("result heading=%0d in_arc=%0b with none outstanding",
                         heading, in_arc));
      end else begin
        r = pending_headings.pop_front();
        if (heading !== r.heading) begin
          report($sformatf("heading got %0d want %0d", heading, r.heading));
        end
        if (in_arc !== r.in_arc) begin
          report($sformatf("in_arc got %0b want %0b (heading %0d)",
                           in_arc, r.in_arc, r.heading));
        end
      end
    endtask

    function int pending();
      return pending_headings.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FIELD_W-1:0]   in_vec_x = '0;
  logic [FIELD_W-1:0]   in_vec_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [HEAD_W-1:0]    out_heading;
  logic                 out_in_arc;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [HEAD_W-1:0]    cfg_data = '0;

  heading_checker sb;
  int             sent_count = 0;

  vector_heading_with_arc_test_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_vec_x    (in_vec_x),
    .in_vec_y    (in_vec_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_heading (out_heading),
    .out_in_arc  (out_in_arc),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bound the run
  initial begin
    #RUN_LIMIT;
    $display("DONE: errors detected");
    $finish;
  end

  // Idle at random, with every fourth stretch of 50 running flat out
  function automatic int draw_gap(int n);
    if ((n / 50) % 4 == 3) begin
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [FIELD_W-1:0] rand_coord();
    logic [FIELD_W-1:0] r;
    r = FIELD_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0: begin
        r = '0;
      end
      1: begin
        r = $unsigned($signed(r) >>> $urandom_range(4, 15));
      end
      2: begin
        r = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one vector request and hold it until taken
  task automatic send_vector(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y);
    int gap;
    gap = draw_gap(sent_count);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vec_x <= x;
    in_vec_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(x, y);
    sent_count++;
  endtask

  // Write one arc register; the caller drops cfg_valid after the last write
  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [HEAD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(idx, data);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Take results with random stalls and one long hold-off
  task automatic drain_results();
    int stall;
    int taken;
    taken = 0;
    forever begin
      stall = draw_gap(taken);
      if (taken == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_heading, out_in_arc);
      taken++;
    end
  endtask

  // Set both limits while idle, then run axis vectors and random vectors
  task automatic run_phase(logic [HEAD_W-1:0] ccw, logic [HEAD_W-1:0] cw, int count);
    wait_drained();
    write_limit(REG_ARC_CCW, ccw);
    write_limit(REG_ARC_CW, cw);
    cfg_valid <= 1'b0;
    send_vector(16'sd0, 16'sd1);
    send_vector(16'sd1, 16'sd0);
    send_vector(16'sd0, -16'sd1);
    send_vector(-16'sd1, 16'sd0);
    for (int i = 0; i < count; i++) begin
      send_vector(rand_coord(), rand_coord());
    end
    in_valid <= 1'b0;
  endtask

  // Put both limits on headings of random vectors and hit them exactly
  task automatic run_edge_phase(int count);
    logic [FIELD_W-1:0] ax;
    logic [FIELD_W-1:0] ay;
    logic [FIELD_W-1:0] bx;
    logic [FIELD_W-1:0] by;
    ax = rand_coord();
    ay = rand_coord();
    bx = rand_coord();
    by = rand_coord();
    run_phase(sb.calc_heading(ax, ay), sb.calc_heading(bx, by), count);
    @(posedge clk);
    send_vector(ax, ay);
    send_vector(bx, by);
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none

    // Directed vectors under the reset limits: zero, axes, extremes, full-turn wrap
    send_vector(16'sd0, 16'sd0);
    send_vector(16'sd0, 16'sd32767);
    send_vector(16'sd32767, 16'sd0);
    send_vector(16'sd0, -16'sd32768);
    send_vector(-16'sd32768, 16'sd0);
    send_vector(16'sd32767, 16'sd32767);
    send_vector(-16'sd32768, -16'sd32768);
    send_vector(-16'sd32768, 16'sd32767);
    send_vector(16'sd32767, -16'sd32768);
    send_vector(16'sd1, 16'sd1);
    send_vector(-16'sd1, -16'sd1);
    send_vector(16'sd1, -16'sd1);
    send_vector(-16'sd1, 16'sd1);
    send_vector(-16'sd1, 16'sd32767);
    send_vector(-16'sd3, 16'sd32767);
    send_vector(-16'sd1, 16'sd1);
    send_vector(16'sd1, -16'sd32768);
    send_vector(-16'sd1, -16'sd32768);
    send_vector(16'sd32767, 16'sd1);
    send_vector(-16'sd32768, -16'sd1);
    send_vector(16'hFFFF, 16'h7FFF);
    in_valid <= 1'b0;

    // Fixed arcs: full, ordinary, wrapping, equal, extremes
    run_phase(16'h0000, 16'hFFFF, 70);
    run_phase(16'd16384, 16'd49152, 70);
    run_phase(16'd49152, 16'd16384, 70);
    run_phase(16'd1000, 16'd1000, 70);
    run_phase(16'hFFFF, 16'h0000, 70);
    run_phase(16'h0000, 16'h0000, 70);
    run_phase(16'hFFFE, 16'hFFFF, 70);
    run_phase(16'h0000, 16'h0001, 70);
    for (int p = 0; p < 6; p++) begin
      run_edge_phase(70);
    end

    // Let the pipeline settle and catch any stray result
    wait_drained();
    repeat (PIPE_DEPTH * 2) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
